FILE: hdl/enurot_pkg.sv
// ----------------------------------------------------------------------------
// enurot_pkg
// shared constants, codes and types for the ecef/enu local frame rotation
// ----------------------------------------------------------------------------
`default_nettype none

package enurot_pkg;

  localparam int COORD_WIDTH_DEF = 40;
  localparam int TRIG_FRAC_DEF   = 30;
  localparam int TRIG_W          = 32;
  localparam int NUM_AXES        = 3;
  localparam int NUM_LANES       = 3;
  localparam int SLICE_W         = 16;
  localparam int PREP_DEPTH      = 2;
  localparam int LANE_DEPTH      = 4;
  localparam int CFG_IDX_W       = 3;

  // trig register order as held in the config block
  localparam int TRIG_SLAT = 0;
  localparam int TRIG_CLAT = 1;
  localparam int TRIG_SLON = 2;
  localparam int TRIG_CLON = 3;
  localparam int NUM_TRIG  = 4;

  // output tuser bits
  localparam int OUT_USER_SAT   = 0;
  localparam int OUT_USER_UNSET = 1;
  localparam int OUT_USER_W     = 2;

  localparam logic FUNC_TO_ENU  = 1'b0;
  localparam logic FUNC_TO_ECEF = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_SIN_LAT      = 3'd3,
    REG_COS_LAT      = 3'd4,
    REG_SIN_LON      = 3'd5,
    REG_COS_LON      = 3'd6,
    REG_ORIGIN_VALID = 3'd7
  } cfg_reg_e;

  // factor that multiplies one coordinate inside a lane
  typedef enum logic [3:0] {
    FAC_ZERO = 4'd0,
    FAC_SLAT = 4'd1,
    FAC_CLAT = 4'd2,
    FAC_SLON = 4'd3,
    FAC_CLON = 4'd4,
    FAC_PSC  = 4'd5,
    FAC_PSS  = 4'd6,
    FAC_PCC  = 4'd7,
    FAC_PCS  = 4'd8
  } fac_e;

  typedef struct packed {
    fac_e fac;
    logic neg;
  } term_op_t;

  typedef struct packed {
    logic valid;
    logic unset;
  } ctl_t;

  // rotation matrix entry for a lane (output axis) and term (input axis)
  function automatic term_op_t lane_op(input logic func, input logic [1:0] lane,
                                       input logic [1:0] term);
    term_op_t op;
    op = '{fac: FAC_ZERO, neg: 1'b0};
    case ({func, lane, term})
      {FUNC_TO_ENU, 2'd0, 2'd0}:  op = '{fac: FAC_SLON, neg: 1'b1};
      {FUNC_TO_ENU, 2'd0, 2'd1}:  op = '{fac: FAC_CLON, neg: 1'b0};
      {FUNC_TO_ENU, 2'd1, 2'd0}:  op = '{fac: FAC_PSC,  neg: 1'b1};
      {FUNC_TO_ENU, 2'd1, 2'd1}:  op = '{fac: FAC_PSS,  neg: 1'b1};
      {FUNC_TO_ENU, 2'd1, 2'd2}:  op = '{fac: FAC_CLAT, neg: 1'b0};
      {FUNC_TO_ENU, 2'd2, 2'd0}:  op = '{fac: FAC_PCC,  neg: 1'b0};
      {FUNC_TO_ENU, 2'd2, 2'd1}:  op = '{fac: FAC_PCS,  neg: 1'b0};
      {FUNC_TO_ENU, 2'd2, 2'd2}:  op = '{fac: FAC_SLAT, neg: 1'b0};
      {FUNC_TO_ECEF, 2'd0, 2'd0}: op = '{fac: FAC_SLON, neg: 1'b1};
      {FUNC_TO_ECEF, 2'd0, 2'd1}: op = '{fac: FAC_PSC,  neg: 1'b1};
      {FUNC_TO_ECEF, 2'd0, 2'd2}: op = '{fac: FAC_PCC,  neg: 1'b0};
      {FUNC_TO_ECEF, 2'd1, 2'd0}: op = '{fac: FAC_CLON, neg: 1'b0};
      {FUNC_TO_ECEF, 2'd1, 2'd1}: op = '{fac: FAC_PSS,  neg: 1'b1};
      {FUNC_TO_ECEF, 2'd1, 2'd2}: op = '{fac: FAC_PCS,  neg: 1'b0};
      {FUNC_TO_ECEF, 2'd2, 2'd1}: op = '{fac: FAC_CLAT, neg: 1'b0};
      {FUNC_TO_ECEF, 2'd2, 2'd2}: op = '{fac: FAC_SLAT, neg: 1'b0};
      default:                    op = '{fac: FAC_ZERO, neg: 1'b0};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/enurot_prep.sv
// ----------------------------------------------------------------------------
// enurot_prep
// origin offset, compound trig factors and per-lane operand selection
// ----------------------------------------------------------------------------
`default_nettype none

module enurot_prep
  import enurot_pkg::*;
#(
  parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
  parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic                                          func_i,
  input  logic signed [COORD_WIDTH-1:0]                 coord_i  [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]                 org_i    [NUM_AXES],
  input  logic signed [TRIG_W-1:0]                      trig_i   [NUM_TRIG],
  output logic signed [2*TRIG_W+1-TRIG_FRACTION_BITS:0] mult_o   [NUM_LANES][NUM_AXES],
  output logic signed [COORD_WIDTH:0]                   opnd_o   [NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]                 addend_o [NUM_LANES]
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PRW  = 2 * TRIG_W;
  localparam int PRW1 = PRW + 1;
  localparam int PW   = PRW + 1 - TRIG_FRACTION_BITS;
  localparam int MW   = PW + 1;

  localparam int PROD_SC = 0;
  localparam int PROD_SS = 1;
  localparam int PROD_CC = 2;
  localparam int PROD_CS = 3;
  localparam int NUM_PROD = 4;

  localparam logic signed [PRW:0] HALF = PRW1'(1) << (TRIG_FRACTION_BITS - 1);

  logic signed [PRW-1:0] prod_r   [NUM_PROD];
  logic signed [DW-1:0]  d_r      [NUM_AXES];
  logic                  func_r;
  logic signed [PRW:0]   psum     [NUM_PROD];
  logic signed [PW-1:0]  pval     [NUM_PROD];
  logic signed [MW-1:0]  mult_nxt [NUM_LANES][NUM_AXES];
  logic signed [MW-1:0]  mult_r   [NUM_LANES][NUM_AXES];
  logic signed [DW-1:0]  opnd_r   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] addend_r [NUM_LANES];

  // stage 1: raw trig products, and coordinate offsets when converting to enu
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[PROD_SC] <= trig_i[TRIG_SLAT] * trig_i[TRIG_CLON];
      prod_r[PROD_SS] <= trig_i[TRIG_SLAT] * trig_i[TRIG_SLON];
      prod_r[PROD_CC] <= trig_i[TRIG_CLAT] * trig_i[TRIG_CLON];
      prod_r[PROD_CS] <= trig_i[TRIG_CLAT] * trig_i[TRIG_SLON];
      for (int i = 0; i < NUM_AXES; i++) begin
        d_r[i] <= (func_i == FUNC_TO_ECEF) ? DW'(coord_i[i])
                                           : DW'(coord_i[i]) - DW'(org_i[i]);
      end
      func_r <= func_i;
    end
  end

  // stage 2: round compound factors, pick signed factor per lane and term
  always_comb begin
    term_op_t             op;
    logic signed [MW-1:0] fv;
    op = '{fac: FAC_ZERO, neg: 1'b0};
    fv = '0;
    for (int p = 0; p < NUM_PROD; p++) begin
      psum[p] = PRW1'(prod_r[p]) + HALF;
      pval[p] = PW'(psum[p] >>> TRIG_FRACTION_BITS);
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int t = 0; t < NUM_AXES; t++) begin
        op = lane_op(func_r, 2'(l), 2'(t));
        case (op.fac)
          FAC_SLAT: fv = MW'(trig_i[TRIG_SLAT]);
          FAC_CLAT: fv = MW'(trig_i[TRIG_CLAT]);
          FAC_SLON: fv = MW'(trig_i[TRIG_SLON]);
          FAC_CLON: fv = MW'(trig_i[TRIG_CLON]);
          FAC_PSC:  fv = MW'(pval[PROD_SC]);
          FAC_PSS:  fv = MW'(pval[PROD_SS]);
          FAC_PCC:  fv = MW'(pval[PROD_CC]);
          FAC_PCS:  fv = MW'(pval[PROD_CS]);
          default:  fv = '0;
        endcase
        mult_nxt[l][t] = op.neg ? -fv : fv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mult_r <= mult_nxt;
      opnd_r <= d_r;
      for (int l = 0; l < NUM_LANES; l++) begin
        addend_r[l] <= (func_r == FUNC_TO_ECEF) ? org_i[l] : '0;
      end
    end
  end

  assign mult_o   = mult_r;
  assign opnd_o   = opnd_r;
  assign addend_o = addend_r;

endmodule

`default_nettype wire

FILE: hdl/enurot_lane.sv
// ----------------------------------------------------------------------------
// enurot_lane
// one matrix row: sliced multiplies, dot product, rounding, origin add, clip
// ----------------------------------------------------------------------------
`default_nettype none

module enurot_lane
  import enurot_pkg::*;
#(
  parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
  parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic signed [2*TRIG_W+1-TRIG_FRACTION_BITS:0] mult_i [NUM_AXES],
  input  logic signed [COORD_WIDTH:0]                   opnd_i [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]                 addend_i,
  output logic signed [COORD_WIDTH-1:0]                 res_o,
  output logic                                          sat_o
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = 2 * TRIG_W + 2 - TRIG_FRACTION_BITS;
  localparam int NSL  = (DW + SLICE_W - 1) / SLICE_W;
  localparam int XW   = NSL * SLICE_W;
  localparam int PPW  = MW + SLICE_W + 1;
  localparam int TPW  = MW + DW;
  localparam int SW   = TPW + 2;
  localparam int RW   = SW - TRIG_FRACTION_BITS;
  localparam int OW   = RW + 1;

  localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRACTION_BITS - 1);
  localparam logic signed [OW-1:0] MAXV = (OW'(1) <<< (COORD_WIDTH - 1)) - OW'(1);
  localparam logic signed [OW-1:0] MINV = -MAXV - OW'(1);

  logic signed [XW-1:0]          dext    [NUM_AXES];
  logic signed [SLICE_W:0]       sl      [NUM_AXES][NSL];
  logic signed [PPW-1:0]         pp_r    [NUM_AXES][NSL];
  logic signed [TPW-1:0]         term_nxt[NUM_AXES];
  logic signed [TPW-1:0]         term_r  [NUM_AXES];
  logic signed [SW-1:0]          sum3;
  logic signed [RW-1:0]          rnd_r;
  logic signed [OW-1:0]          tot;
  logic signed [COORD_WIDTH-1:0] add1_r, add2_r, add3_r;
  logic signed [COORD_WIDTH-1:0] res_nxt, res_r;
  logic                          sat_nxt, sat_r;

  // coordinate cut into 16-bit digits, top digit signed
  always_comb begin
    for (int t = 0; t < NUM_AXES; t++) begin
      dext[t] = XW'(opnd_i[t]);
      for (int k = 0; k < NSL; k++) begin
        if (k == NSL - 1) begin
          sl[t][k] = $signed({dext[t][XW-1], dext[t][k*SLICE_W +: SLICE_W]});
        end else begin
          sl[t][k] = $signed({1'b0, dext[t][k*SLICE_W +: SLICE_W]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NUM_AXES; t++) begin
        for (int k = 0; k < NSL; k++) begin
          pp_r[t][k] <= mult_i[t] * sl[t][k];
        end
      end
      add1_r <= addend_i;
    end
  end

  // weighted digit products back into one term
  always_comb begin
    for (int t = 0; t < NUM_AXES; t++) begin
      term_nxt[t] = '0;
      for (int k = 0; k < NSL; k++) begin
        term_nxt[t] = term_nxt[t] + (TPW'(pp_r[t][k]) <<< (SLICE_W * k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      add2_r <= add1_r;
    end
  end

  assign sum3 = SW'(term_r[0]) + SW'(term_r[1]) + SW'(term_r[2]) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r  <= RW'(sum3 >>> TRIG_FRACTION_BITS);
      add3_r <= add2_r;
    end
  end

  // origin add and clip to the coordinate range
  always_comb begin
    tot = OW'(rnd_r) + OW'(add3_r);
    if (tot > MAXV) begin
      res_nxt = COORD_WIDTH'(MAXV);
      sat_nxt = 1'b1;
    end else if (tot < MINV) begin
      res_nxt = COORD_WIDTH'(MINV);
      sat_nxt = 1'b1;
    end else begin
      res_nxt = COORD_WIDTH'(tot);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire

FILE: hdl/enurot_merge.sv
// ----------------------------------------------------------------------------
// enurot_merge
// combines lane results and flags into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module enurot_merge
  import enurot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  ctl_t                                            last_i,
  input  logic signed [COORD_WIDTH-1:0]                   res_i [NUM_LANES],
  input  logic                                            sat_i [NUM_LANES],
  input  logic                                            out_tready,
  output logic                                            en_o,
  output logic                                            out_tvalid,
  output logic [((NUM_LANES*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]                           out_tuser
);

  localparam int ODW = ((NUM_LANES * COORD_WIDTH + 7) / 8) * 8;

  logic                  out_ready_int;
  logic                  out_valid_r;
  logic [ODW-1:0]        data_nxt, data_r;
  logic [OUT_USER_W-1:0] user_nxt, user_r;
  logic                  any_sat;

  assign out_ready_int = !out_valid_r || out_tready;
  // pipeline moves whenever the output register frees up or the last stage is empty
  assign en_o          = out_ready_int || !last_i.valid;

  always_comb begin
    any_sat  = 1'b0;
    data_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      any_sat = any_sat | sat_i[l];
      if (!last_i.unset) begin
        data_nxt[l*COORD_WIDTH +: COORD_WIDTH] = res_i[l];
      end
    end
    user_nxt                 = '0;
    user_nxt[OUT_USER_SAT]   = any_sat && !last_i.unset;
    user_nxt[OUT_USER_UNSET] = last_i.unset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= last_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int && last_i.valid) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

`default_nettype wire

FILE: hdl/ecef_enu_local_frame_rotation_top.sv
// ----------------------------------------------------------------------------
// ecef_enu_local_frame_rotation_top
// rotates one vector per transfer between ecef and local east/north/up frames
// ----------------------------------------------------------------------------
// depth: 2 prep stages, 4 lane stages, then 1 output register
// throughput: one vector per cycle unless a held output stalls the pipeline
// reset: synchronous, active low; clears config registers and stage valids
`default_nettype none

module ecef_enu_local_frame_rotation_top
  import enurot_pkg::*;
#(
  parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
  parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // input stream
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // tdata: coord_a, coord_b, coord_c (COORD_WIDTH each), zero pad
  input  logic [((NUM_AXES*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // tuser: func (0 ecef to enu, 1 enu to ecef)
  input  logic                                            in_tuser,
  // result stream
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // tdata: out_a, out_b, out_c (COORD_WIDTH each), zero pad
  output logic [((NUM_LANES*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  // tuser: saturated, origin_unset
  output logic [OUT_USER_W-1:0]                           out_tuser,
  // config write channel
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]                            cfg_index,
  input  logic [(COORD_WIDTH > TRIG_W ? COORD_WIDTH : TRIG_W)-1:0] cfg_data
);

  localparam int MW   = 2 * TRIG_W + 2 - TRIG_FRACTION_BITS;
  localparam int NST  = PREP_DEPTH + LANE_DEPTH;

  // config registers
  logic signed [COORD_WIDTH-1:0] org_r  [NUM_AXES];
  logic signed [TRIG_W-1:0]      trig_r [NUM_TRIG];
  logic                          org_valid_r;

  // pipeline control, one entry per stage
  ctl_t                          ctl_r  [NST];
  logic                          en;

  logic signed [COORD_WIDTH-1:0] coord  [NUM_AXES];
  logic signed [MW-1:0]          mult   [NUM_LANES][NUM_AXES];
  logic signed [COORD_WIDTH:0]   opnd   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] addend [NUM_LANES];
  logic signed [COORD_WIDTH-1:0] res    [NUM_LANES];
  logic                          sat    [NUM_LANES];

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) org_r[i] <= '0;
      for (int i = 0; i < NUM_TRIG; i++) trig_r[i] <= '0;
      org_valid_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_ORIGIN_X:     org_r[0]          <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y:     org_r[1]          <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z:     org_r[2]          <= cfg_data[COORD_WIDTH-1:0];
        REG_SIN_LAT:      trig_r[TRIG_SLAT] <= cfg_data[TRIG_W-1:0];
        REG_COS_LAT:      trig_r[TRIG_CLAT] <= cfg_data[TRIG_W-1:0];
        REG_SIN_LON:      trig_r[TRIG_SLON] <= cfg_data[TRIG_W-1:0];
        REG_COS_LON:      trig_r[TRIG_CLON] <= cfg_data[TRIG_W-1:0];
        REG_ORIGIN_VALID: org_valid_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input transfer happens whenever the pipeline advances
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      coord[i] = in_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // valid and origin-unset flag ride alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: in_tvalid, unset: !org_valid_r};
      for (int i = 1; i < NST; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  // offsets, compound trig factors, per-lane factor select
  enurot_prep #(
    .COORD_WIDTH        (COORD_WIDTH),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_prep (
    .clk      (clk),
    .en       (en),
    .func_i   (in_tuser),
    .coord_i  (coord),
    .org_i    (org_r),
    .trig_i   (trig_r),
    .mult_o   (mult),
    .opnd_o   (opnd),
    .addend_o (addend)
  );

  // one lane per output axis
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    enurot_lane #(
      .COORD_WIDTH        (COORD_WIDTH),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (en),
      .mult_i   (mult[l]),
      .opnd_i   (opnd),
      .addend_i (addend[l]),
      .res_o    (res[l]),
      .sat_o    (sat[l])
    );
  end

  // flag merge, zeroing when no origin, output register
  enurot_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_i     (ctl_r[NST-1]),
    .res_i      (res),
    .sat_i      (sat),
    .out_tready (out_tready),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: hdl/enurot_checker.sv
// ----------------------------------------------------------------------------
// enurot_checker
// port-level checks on the frame rotation block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module enurot_checker
  import enurot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                                            clk,
  input logic                                            rst_n,
  input logic                                            in_tready,
  input logic                                            out_tvalid,
  input logic                                            out_tready,
  input logic [((NUM_LANES*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  input logic [OUT_USER_W-1:0]                           out_tuser
);

  // no origin means all-zero coordinates and no clip flag
  a_unset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_USER_UNSET] |->
      out_tdata == '0 && !out_tuser[OUT_USER_SAT])
    else $error("origin unset result not zeroed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // an empty output register never back-pressures the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ecef_enu_local_frame_rotation_top enurot_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_enurot_checker (.*);

`default_nettype wire
